// ----- rtl/core/tdes_pkg.sv -----
// Triple-DES package: widths, register indexes and the DES permutation,
// S-box and key-schedule functions. No dependencies.
`default_nettype none
package tdes_pkg;

   localparam int NumRounds = 48;
   localparam logic [1:0] REG_KEY_ONE   = 2'd0;
   localparam logic [1:0] REG_KEY_TWO   = 2'd1;
   localparam logic [1:0] REG_KEY_THREE = 2'd2;

   typedef struct packed {
      logic [1:0] key_sel;
      logic       decrypt;
      logic [3:0] round;
   } round_ctl_type;

   localparam byte unsigned IP_TAB[64] = '{
      58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
   localparam byte unsigned FP_TAB[64] = '{
      40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
   localparam byte unsigned E_TAB[48] = '{
      32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
      16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
   localparam byte unsigned P_TAB[32] = '{
      16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
   localparam byte unsigned PC1_TAB[56] = '{
      57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
      60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
      29,21,13,5,28,20,12,4};
   localparam byte unsigned PC2_TAB[48] = '{
      14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
      41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
   // cumulative left rotation of C and D after round r
   localparam byte unsigned ROT_TAB[16] = '{1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28};
   localparam byte unsigned S_TAB[8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   function automatic logic [63:0] ip_perm(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = v[64-IP_TAB[i]];
      return r;
   endfunction

   function automatic logic [63:0] fp_perm(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = v[64-FP_TAB[i]];
      return r;
   endfunction

   // round subkey straight from the key: PC-1, fixed rotation, PC-2
   function automatic logic [47:0] subkey(input logic [63:0] key, input logic [3:0] rnd);
      logic [55:0] cd;
      logic [27:0] c;
      logic [27:0] d;
      logic [55:0] rcd;
      logic [47:0] k;
      for (int i = 0; i < 56; i++) cd[55-i] = key[64-PC1_TAB[i]];
      c = cd[55:28];
      d = cd[27:0];
      rcd = '0;
      for (int r = 0; r < 16; r++) begin
         if (rnd == 4'(r)) begin
            rcd = {(c << ROT_TAB[r]) | (c >> (28 - ROT_TAB[r])),
                   (d << ROT_TAB[r]) | (d >> (28 - ROT_TAB[r]))};
         end
      end
      for (int i = 0; i < 48; i++) k[47-i] = rcd[56-PC2_TAB[i]];
      return k;
   endfunction

   function automatic logic [31:0] feistel(input logic [31:0] h, input logic [47:0] k);
      logic [47:0] e;
      logic [31:0] s;
      logic [31:0] p;
      logic [5:0]  six;
      for (int i = 0; i < 48; i++) e[47-i] = h[32-E_TAB[i]];
      e = e ^ k;
      for (int i = 0; i < 8; i++) begin
         six = e[47-6*i -: 6];
         s[31-4*i -: 4] = 4'(S_TAB[i][{six[5], six[0], six[4:1]}]);
      end
      for (int i = 0; i < 32; i++) p[31-i] = s[32-P_TAB[i]];
      return p;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tdes_round.sv -----
// One registered DES Feistel round with its own subkey selection.
// Depends on tdes_pkg.
`default_nettype none
module tdes_round
   import tdes_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire round_ctl_type ctl,
   input  wire logic [63:0]   key_one,
   input  wire logic [63:0]   key_two,
   input  wire logic [63:0]   key_three,
   input  wire logic          valid_in,
   input  wire logic          kind_in,
   input  wire logic [63:0]   lr_in,
   output logic               valid_ff,
   output logic               kind_ff,
   output logic [63:0]        lr_ff
);
   logic [63:0] key;
   logic [3:0]  rnd;
   logic [63:0] lr_in_next;
   logic [1:0]  sel;

   always_comb begin
      // decrypt direction reverses the key order
      sel = kind_in ? (2'd2 - ctl.key_sel) : ctl.key_sel;
      case (sel)
         REG_KEY_ONE:   key = key_one;
         REG_KEY_TWO:   key = key_two;
         default:       key = key_three;
      endcase
      rnd = (ctl.decrypt ^ kind_in) ? (4'd15 - ctl.round) : ctl.round;
      lr_in_next = {lr_in[31:0], lr_in[63:32] ^ feistel(lr_in[31:0], subkey(key, rnd))};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         kind_ff <= kind_in;
         lr_ff   <= lr_in_next;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/triple_des_block_cipher.sv -----
// Triple-DES EDE3 engine: 48 unrolled round stages plus an output register.
// One request per cycle sustained while the result side is not holding.
// The whole pipeline advances together and holds when the result waits.
// Synchronous reset clears valid bits and the three keys to zero.
// Depends on tdes_pkg and tdes_round.
`default_nettype none
module triple_des_block_cipher
   import tdes_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [63:0] req_block_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_block_out,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);
   logic [63:0] key_one_ff, key_two_ff, key_three_ff;
   logic        valid_s [NumRounds+1];
   logic        kind_s  [NumRounds+1];
   logic [63:0] lr_s    [NumRounds+1];
   logic        advance;
   logic [1:0]  reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:3];
   assign advance = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      case (reg_idx)
         REG_KEY_ONE:   prdata = key_one_ff;
         REG_KEY_TWO:   prdata = key_two_ff;
         REG_KEY_THREE: prdata = key_three_ff;
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_one_ff   <= '0;
         key_two_ff   <= '0;
         key_three_ff <= '0;
      end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
         case (reg_idx)
            REG_KEY_ONE:   key_one_ff   <= pwdata;
            REG_KEY_TWO:   key_two_ff   <= pwdata;
            REG_KEY_THREE: key_three_ff <= pwdata;
            default:       ;
         endcase
      end
   end

   assign valid_s[0] = req_valid;
   assign kind_s[0]  = req_kind;
   assign lr_s[0]    = ip_perm(req_block_in);

   for (genvar g = 0; g < NumRounds; g++) begin : g_round
      round_ctl_type ctl;
      logic [63:0] lr_src;
      assign ctl.key_sel = 2'(g / 16);
      assign ctl.decrypt = ((g / 16) == 1);
      assign ctl.round   = 4'(g % 16);
      // between DES passes: swap halves, FP, then IP of the next pass
      if (g % 16 == 0 && g != 0) begin : g_join
         assign lr_src = ip_perm(fp_perm({lr_s[g][31:0], lr_s[g][63:32]}));
      end else begin : g_plain
         assign lr_src = lr_s[g];
      end
      tdes_round u_round (
         .clock, .reset, .advance, .ctl,
         .key_one(key_one_ff), .key_two(key_two_ff), .key_three(key_three_ff),
         .valid_in(valid_s[g]), .kind_in(kind_s[g]), .lr_in(lr_src),
         .valid_ff(valid_s[g+1]), .kind_ff(kind_s[g+1]), .lr_ff(lr_s[g+1])
      );
   end

   logic rsp_valid_ff;
   logic [63:0] rsp_block_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_s[NumRounds];
      end
      if (advance) begin
         rsp_block_ff <= fp_perm({lr_s[NumRounds][31:0], lr_s[NumRounds][63:32]});
      end
   end
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = rsp_block_ff;
endmodule
`default_nettype wire
